// ===== design/swms_pkg.sv =====
// Package: shared constants and types for the sliding-window mean/stddev block.
`default_nettype none
package swms_pkg;
  localparam int unsigned WindowDepth = 64;
  localparam int unsigned SlotW = $clog2(WindowDepth);
  localparam int unsigned CountW = $clog2(WindowDepth + 1);
  localparam int unsigned SumW = 16 + CountW;
  localparam int unsigned SqW = 32 + CountW;
  localparam int unsigned VarW = 32;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

  typedef struct packed {
    logic clear_win;
    logic push;
    logic start_sum;
    logic step_sum;
    logic start_mean;
    logic step_div;
    logic start_dev;
    logic step_dev;
    logic start_var;
    logic start_sqrt;
    logic step_sqrt;
    logic load_out;
  } swms_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic sqrt_done;
    logic empty;
  } swms_sts_t;
endpackage
`default_nettype wire

// ===== design/swms_if.sv =====
// Interfaces: input and result channels with valid/ready handshake.
`default_nettype none
interface swms_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic signed [15:0] sample;
  modport source (output valid, mode, sample, input ready);
  modport sink (input valid, mode, sample, output ready);
endinterface

interface swms_out_if;
  logic valid;
  logic ready;
  logic [6:0] entry_count;
  logic signed [21:0] window_sum;
  logic signed [15:0] mean_value;
  logic [15:0] std_dev;
  logic evicted_valid;
  logic signed [15:0] evicted_sample;
  modport source (output valid, entry_count, window_sum, mean_value, std_dev,
                  evicted_valid, evicted_sample, input ready);
  modport sink (input valid, entry_count, window_sum, mean_value, std_dev,
                evicted_valid, evicted_sample, output ready);
endinterface
`default_nettype wire

// ===== design/swms_datapath.sv =====
// Datapath: sample ring, accumulators, serial divider and serial square root.
`default_nettype none
module swms_datapath (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire swms_pkg::swms_cmd_t cmd_i,
  output swms_pkg::swms_sts_t sts_o,
  input  wire logic signed [15:0] sample_i,
  input  wire logic [6:0] wlen_i,
  output logic [6:0] entry_count_o,
  output logic signed [21:0] window_sum_o,
  output logic signed [15:0] mean_value_o,
  output logic [15:0] std_dev_o,
  output logic evicted_valid_o,
  output logic signed [15:0] evicted_sample_o
);
  import swms_pkg::*;

  logic signed [15:0] mem_q [WindowDepth];
  logic signed [15:0] rd_q;
  logic [CountW-1:0] fill_q, fill_d, idx_q;
  logic [SlotW-1:0] oldest_q, oldest_d, rd_addr, wr_addr;
  logic ev_q, ev_d;
  logic signed [15:0] evs_q, evs_d;
  logic [CountW-1:0] elen;
  logic signed [SumW-1:0] sum_q;
  logic [SqW-1:0] sq_q;
  logic signed [15:0] mean_q;
  // divider
  logic [SqW-1:0] quo_q, rem_q;
  logic [6:0] dcnt_q;
  logic neg_q;
  logic [SqW:0] trial;
  // sqrt
  logic [VarW-1:0] sv_q, root_q, sbit_q;
  logic [15:0] std_q;
  logic [VarW-1:0] rb;
  logic signed [16:0] dev;
  logic [15:0] adev;
  logic scan_pend_q;
  logic scan_issue;

  function automatic logic [SlotW-1:0] wrap(input logic [SlotW:0] s);
    logic [SlotW:0] r;
    r = s;
    if (r >= (SlotW+1)'(WindowDepth)) r = r - (SlotW+1)'(WindowDepth);
    return r[SlotW-1:0];
  endfunction

  always_comb begin
    elen = (wlen_i == 7'd0) ? CountW'(1) :
           (32'(wlen_i) > WindowDepth) ? CountW'(WindowDepth) : CountW'(wlen_i);
  end

  always_comb begin
    fill_d = fill_q;
    oldest_d = oldest_q;
    ev_d = 1'b0;
    evs_d = '0;
    if (fill_q >= elen) begin
      ev_d = 1'b1;
      evs_d = rd_q;
      oldest_d = wrap({1'b0, oldest_q} + (SlotW+1)'(1));
      fill_d = fill_q - CountW'(1);
    end
    wr_addr = wrap({1'b0, oldest_d} + (SlotW+1)'(fill_d[SlotW-1:0]));
    fill_d = fill_d + CountW'(1);
  end

  // read address: oldest plus scan index; index is zero during push prep
  assign rd_addr = wrap({1'b0, oldest_q} + (SlotW+1)'(idx_q[SlotW-1:0]));

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (cmd_i.push) mem_q[wr_addr] <= sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      oldest_q <= '0;
      ev_q <= 1'b0;
      evs_q <= '0;
    end else if (cmd_i.clear_win) begin
      fill_q <= '0;
      oldest_q <= '0;
      ev_q <= 1'b0;
      evs_q <= '0;
    end else if (cmd_i.push) begin
      fill_q <= fill_d;
      oldest_q <= oldest_d;
      ev_q <= ev_d;
      evs_q <= evs_d;
    end
  end

  assign dev = 17'(rd_q) - 17'(mean_q);
  assign adev = dev[16] ? 16'(-dev) : dev[15:0];

  // scans: idx counts reads issued; rd_q is registered and valid in the cycle after issue
  assign scan_issue = (idx_q < fill_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_sum || cmd_i.start_dev) begin
      idx_q <= '0;
      scan_pend_q <= 1'b0;
    end else if (cmd_i.step_sum || cmd_i.step_dev) begin
      if (scan_issue) idx_q <= idx_q + CountW'(1);
      scan_pend_q <= scan_issue;
    end else begin
      scan_pend_q <= 1'b0;
    end
    if (cmd_i.start_sum) sum_q <= '0;
    else if (cmd_i.step_sum && scan_pend_q) sum_q <= sum_q + SumW'(rd_q);
    if (cmd_i.start_dev) sq_q <= '0;
    else if (cmd_i.step_dev && scan_pend_q) sq_q <= sq_q + SqW'(adev * adev);
  end
  assign sts_o.scan_done = !scan_issue && !scan_pend_q;
  assign sts_o.empty = (fill_q == '0);

  // restoring divider, shared by mean and variance
  assign trial = {rem_q, quo_q[SqW-1]} - (SqW+1)'(fill_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_mean) begin
      neg_q <= sum_q[SumW-1];
      quo_q <= SqW'(sum_q[SumW-1] ? -sum_q : sum_q);
      rem_q <= '0;
      dcnt_q <= 7'(SqW);
    end else if (cmd_i.start_var) begin
      neg_q <= 1'b0;
      quo_q <= sq_q;
      rem_q <= '0;
      dcnt_q <= 7'(SqW);
    end else if (cmd_i.step_div && dcnt_q != 7'd0) begin
      if (!trial[SqW]) begin
        rem_q <= trial[SqW-1:0];
        quo_q <= {quo_q[SqW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[SqW-2:0], quo_q[SqW-1]};
        quo_q <= {quo_q[SqW-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 7'd1;
    end
    if (cmd_i.start_dev) mean_q <= 16'(neg_q ? -quo_q : quo_q);
    if (cmd_i.clear_win || cmd_i.push) mean_q <= '0;
  end
  assign sts_o.div_done = (dcnt_q == 7'd0);

  // digit-by-digit square root, one result bit per step
  assign rb = root_q + sbit_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_sqrt) begin
      sv_q <= quo_q[SqW-1:VarW] != '0 ? '1 : quo_q[VarW-1:0];
      root_q <= '0;
      sbit_q <= VarW'(1) << (VarW - 2);
    end else if (cmd_i.step_sqrt && sbit_q != '0) begin
      if (sv_q >= rb) begin
        sv_q <= sv_q - rb;
        root_q <= (root_q >> 1) + sbit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end
  assign sts_o.sqrt_done = (sbit_q == '0);
  assign std_q = root_q[15:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      entry_count_o <= 7'(fill_q);
      evicted_valid_o <= ev_q;
      evicted_sample_o <= evs_q;
      if (fill_q == '0) begin
        window_sum_o <= '0;
        mean_value_o <= '0;
        std_dev_o <= '0;
      end else begin
        window_sum_o <= 22'(sum_q);
        mean_value_o <= mean_q;
        std_dev_o <= std_q;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/swms_ctrl.sv =====
// Controller: sequences clear or push, scans, divides, square root and the result beat.
`default_nettype none
module swms_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_mode_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output swms_pkg::swms_cmd_t cmd_o,
  input  wire swms_pkg::swms_sts_t sts_i
);
  import swms_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_PUSH = 4'd2;
  localparam logic [3:0] S_SUM = 4'd3;
  localparam logic [3:0] S_MDIV = 4'd4;
  localparam logic [3:0] S_DEV = 4'd5;
  localparam logic [3:0] S_VDIV = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [3:0] state_q, state_d;
  logic ov_q, ov_d;
  logic accept;

  // the output register holds a finished beat while the next item runs
  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d = ov_q && !out_ready_i;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_mode_i == MODE_CLEAR) begin
            cmd_o.clear_win = 1'b1;
            state_d = S_OUT;
          end else begin
            cmd_o.start_sum = 1'b1;
            state_d = S_PREP;
          end
        end
      end
      S_PREP: state_d = S_PUSH;
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.step_sum = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.start_mean = 1'b1;
          state_d = S_MDIV;
        end
      end
      S_MDIV: begin
        cmd_o.step_div = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.step_div = 1'b0;
          cmd_o.start_dev = 1'b1;
          state_d = S_DEV;
        end
      end
      S_DEV: begin
        cmd_o.step_dev = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.start_var = 1'b1;
          state_d = S_VDIV;
        end
      end
      S_VDIV: begin
        cmd_o.step_div = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.step_div = 1'b0;
          cmd_o.start_sqrt = 1'b1;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.step_sqrt = 1'b1;
        if (sts_i.sqrt_done) begin
          cmd_o.step_sqrt = 1'b0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end
endmodule
`default_nettype wire

// ===== design/sliding_window_mean_stddev.sv =====
// Top level: sliding-window mean and standard deviation with APB length register.
// Sequence for a push: prep, push, a sum scan over the N samples held, a 39-step mean
// divide, a deviation scan, a 39-step variance divide, a 16-step square root, load.
// One item at a time, a clear going straight to the load; the next item is taken
// while a finished result waits.
// Reset: asynchronous active low; window empties, length register returns to 64.
`default_nettype none
module sliding_window_mean_stddev (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  swms_in_if.sink in_if,
  swms_out_if.source out_if,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [0:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import swms_pkg::*;

  swms_cmd_t cmd;
  swms_sts_t sts;
  logic [6:0] wlen_q;
  logic signed [15:0] samp_q;

  assign pready = 1'b1;
  assign prdata = {25'd0, wlen_q};

  // length register; address is a word index stub (single register at 0)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= 7'd64;
    end else if (psel && penable && pwrite && paddr == REG_WINDOW_LENGTH) begin
      wlen_q <= pwdata[6:0];
    end
  end

  // hold the pushed sample for the write cycle
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) samp_q <= in_if.sample;
  end

  swms_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_mode_i(in_if.mode), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  swms_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .sample_i(samp_q), .wlen_i(wlen_q),
    .entry_count_o(out_if.entry_count), .window_sum_o(out_if.window_sum),
    .mean_value_o(out_if.mean_value), .std_dev_o(out_if.std_dev),
    .evicted_valid_o(out_if.evicted_valid), .evicted_sample_o(out_if.evicted_sample)
  );

`ifndef SYNTHESIS
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.window_sum))
    else $error("result beat changed while waiting");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.entry_count <= 7'(WindowDepth)) else $error("count");
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.evicted_valid |-> out_if.evicted_sample == 16'sd0)
    else $error("evicted sample nonzero");
`endif
endmodule
`default_nettype wire

// ===== bench/sliding_window_mean_stddev_tb.sv =====
// Testbench: sliding-window mean/stddev block checked beat by beat against a window predictor.
`default_nettype none
module sliding_window_mean_stddev_tb;
  import swms_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHold = 600;
  localparam int unsigned DrainCycles = 300;

  typedef struct packed {
    logic [6:0] entry_count;
    logic signed [21:0] window_sum;
    logic signed [15:0] mean_value;
    logic [15:0] std_dev;
    logic evicted_valid;
    logic signed [15:0] evicted_sample;
  } stats_t;

  // one row of the directed table; stats are typed in only where pinned is set
  typedef struct packed {
    logic mode;
    logic signed [15:0] sample;
    logic pinned;
    stats_t stats;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [0:0] paddr = REG_WINDOW_LENGTH;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  swms_in_if in_if ();
  swms_out_if out_if ();

  sliding_window_mean_stddev dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if.sink),
    .out_if(out_if.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk_i = ~clk_i;

  // predictor state: held samples oldest first, and the length register
  logic signed [15:0] held_q[$];
  logic [6:0] length_reg = 7'd64;
  stats_t stats_q[$];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned evictions = 0;
  int unsigned clears = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  function automatic logic [15:0] isqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return (root > 65535) ? 16'hFFFF : root[15:0];
  endfunction

  // applies one accepted beat to the window and returns its statistics
  function automatic stats_t window_step(input logic mode, input logic signed [15:0] smp);
    stats_t r;
    int unsigned lim;
    int total;
    int mean;
    longint d;
    longint unsigned sq;
    r = '0;
    lim = (length_reg == 0) ? 1 : (length_reg > WindowDepth) ? WindowDepth : length_reg;
    if (mode == MODE_CLEAR) begin
      held_q.delete();
    end else begin
      if (held_q.size() >= lim) begin
        r.evicted_valid = 1'b1;
        r.evicted_sample = held_q[0];
        held_q.delete(0);
      end
      held_q.push_back(smp);
    end
    total = 0;
    sq = 0;
    foreach (held_q[i]) total += held_q[i];
    if (held_q.size() > 0) begin
      mean = total / int'(held_q.size());
      foreach (held_q[i]) begin
        d = longint'(held_q[i]) - mean;
        sq += longint'(d * d);
      end
      r.mean_value = mean[15:0];
      r.std_dev = isqrt(sq / held_q.size());
    end
    r.entry_count = 7'(held_q.size());
    r.window_sum = total[21:0];
    return r;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic apb_write(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_WINDOW_LENGTH;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    length_reg = value[6:0];
  endtask

  // one input beat; random gap first, then hold valid until accepted
  task automatic send_beat(input logic mode, input logic signed [15:0] smp,
                           input logic pinned, input stats_t pinned_stats);
    stats_t p;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= mode;
    in_if.sample <= smp;
    do @(posedge clk_i); while (!in_if.ready);
    p = window_step(mode, smp);
    stats_q.push_back(pinned ? pinned_stats : p);
    beats_in++;
    if (mode == MODE_CLEAR) clears++;
  endtask

  task automatic idle_until_drained();
    in_if.valid <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned clear_odds);
    repeat (n) begin
      if ($urandom_range(0, clear_odds) == 0) send_beat(MODE_CLEAR, pick_sample(), 1'b0, '0);
      else send_beat(MODE_PUSH, pick_sample(), 1'b0, '0);
    end
  endtask

  // result side: random stall bursts, one long hold on request, field check per beat
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    stats_t e;
    stats_t a;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        beats_out++;
        a = '{out_if.entry_count, out_if.window_sum, out_if.mean_value,
              out_if.std_dev, out_if.evicted_valid, out_if.evicted_sample};
        if (a.evicted_valid) evictions++;
        if (stats_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", a);
        end else begin
          e = stats_q[0];
          stats_q.delete(0);
          if (a.entry_count !== e.entry_count || a.window_sum !== e.window_sum ||
              a.mean_value !== e.mean_value || a.std_dev !== e.std_dev ||
              a.evicted_valid !== e.evicted_valid ||
              a.evicted_sample !== e.evicted_sample) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: exp %p got %p", e, a);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LongHold;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // directed table; pinned rows carry stats readable by hand
  step_row_t dir_tab[$] = '{
    '{MODE_CLEAR, 16'sh1234, 1'b1, '{7'd0, 22'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0}},
    '{MODE_PUSH, 16'sh7FFF, 1'b1, '{7'd1, 22'sd32767, 16'sd32767, 16'd0, 1'b0, 16'sd0}},
    // two opposite extremes: mean truncates to 0, deviation 32767
    '{MODE_PUSH, 16'sh8000, 1'b1, '{7'd2, -22'sd1, 16'sd0, 16'd32767, 1'b0, 16'sd0}},
    '{MODE_PUSH, 16'sh0000, 1'b0, '0},
    '{MODE_PUSH, 16'sh0001, 1'b0, '0},
    '{MODE_PUSH, 16'shFFFF, 1'b0, '0},
    '{MODE_CLEAR, 16'shFFFF, 1'b1, '{7'd0, 22'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0}},
    '{MODE_PUSH, 16'sh8000, 1'b1, '{7'd1, -22'sd32768, -16'sd32768, 16'd0, 1'b0, 16'sd0}},
    '{MODE_CLEAR, 16'sh0000, 1'b1, '{7'd0, 22'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0}},
    // negative mean truncates toward zero: -3/2 -> -1
    '{MODE_PUSH, -16'sd3, 1'b1, '{7'd1, -22'sd3, -16'sd3, 16'd0, 1'b0, 16'sd0}},
    '{MODE_PUSH, 16'sd0, 1'b1, '{7'd2, -22'sd3, -16'sd1, 16'd1, 1'b0, 16'sd0}},
    '{MODE_PUSH, 16'sh5555, 1'b0, '0},
    '{MODE_PUSH, 16'shAAAA, 1'b0, '0},
    '{MODE_CLEAR, 16'sh0000, 1'b0, '0}
  };

  int unsigned lengths[] = '{1, 0, 127, 2, 17, 5, 64, 33};

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = MODE_PUSH;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_beat(dir_tab[i].mode, dir_tab[i].sample, dir_tab[i].pinned, dir_tab[i].stats);

    // full window of each extreme: sum limits and steady eviction
    repeat (64) send_beat(MODE_PUSH, 16'sh8000, 1'b0, '0);
    repeat (66) send_beat(MODE_PUSH, 16'sh7FFF, 1'b0, '0);
    idle_until_drained();

    foreach (lengths[k]) begin
      apb_write(lengths[k]);
      if (k == 2) hold_req = 1'b1;    // long receiver hold while beats keep coming
      random_phase(70, 30);
      idle_until_drained();
    end

    // lower the length below the held count: window must not grow, only shift
    apb_write(64);
    send_beat(MODE_CLEAR, 16'sd0, 1'b0, '0);
    random_phase(20, 1000);
    idle_until_drained();
    apb_write(3);
    random_phase(30, 1000);
    idle_until_drained();

    // last stretch: no idling on either side
    apb_write(9);
    quiet = 1'b1;
    random_phase(60, 25);
    idle_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d beats (%0d clears), got %0d results, %0d evictions, %0d mismatches",
             beats_in, clears, beats_out, evictions, mismatches);
    $display("lengths covered 0,1,2,3,5,9,17,33,64,127 plus a shrink below the held count");
    if (mismatches == 0 && stats_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/swms_pkg.sv
design/swms_if.sv
design/swms_datapath.sv
design/swms_ctrl.sv
design/sliding_window_mean_stddev.sv
bench/sliding_window_mean_stddev_tb.sv
